// ===== hdl/assert_macros.svh =====
// Assertion macros used by websocket_frame_deframer, the RTL top of the frame deframer.
// Included by bare name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge while out of reset.
`define WSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that cond never holds while out of reset.
`define WSD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/wsd_pkg.sv =====
// Types and constants of the WebSocket frame deframer.
// No dependencies; used by wsd_parser and websocket_frame_deframer.
`default_nettype none

package wsd_pkg;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // One result of a parsed byte, valid when a byte or empty marker leaves
    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic [6:0] frame_kind;
        logic       frame_end;
        logic       empty_frame;
    } wsd_result_t;

endpackage

`default_nettype wire

// ===== hdl/wsd_parser.sv =====
// Frame header state machine and payload unmasking of the deframer.
// Depends on wsd_pkg; one byte is consumed per cycle in which step is high.
`default_nettype none

module wsd_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    output wsd_pkg::wsd_result_t    result
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  kind_reg, kind_next;
    logic        masked_reg, masked_next;
    logic [3:0]  ext_cnt_reg, ext_cnt_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_idx_reg, key_idx_next;

    logic [63:0] ext_len;
    logic [7:0]  key_byte;

    assign ext_len = {remaining_reg[55:0], rx_byte};

    always_comb begin
        unique case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        masked_next    = masked_reg;
        ext_cnt_next   = ext_cnt_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;

        result              = '0;
        result.frame_kind   = kind_reg;

        unique case (phase_reg)
            PH_SECOND: begin
                masked_next    = rx_byte[7];
                remaining_next = '0;
                if (rx_byte[6:0] == LEN_EXT16) begin
                    ext_cnt_next = EXT16_BYTES;
                    phase_next   = PH_EXTLEN;
                end else if (rx_byte[6:0] == LEN_EXT64) begin
                    ext_cnt_next = EXT64_BYTES;
                    phase_next   = PH_EXTLEN;
                end else begin
                    remaining_next = {57'd0, rx_byte[6:0]};
                    key_idx_next   = 2'd0;
                    if (rx_byte[7]) begin
                        key_next   = '0;
                        phase_next = PH_KEY;
                    end else if (rx_byte[6:0] == 7'd0) begin
                        result.valid       = 1'b1;
                        result.frame_end   = 1'b1;
                        result.empty_frame = 1'b1;
                        phase_next         = PH_FIRST;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                remaining_next = ext_len;
                ext_cnt_next   = ext_cnt_reg - 4'd1;
                if (ext_cnt_reg == 4'd1) begin
                    key_idx_next = 2'd0;
                    if (masked_reg) begin
                        key_next   = '0;
                        phase_next = PH_KEY;
                    end else if (ext_len == 64'd0) begin
                        result.valid       = 1'b1;
                        result.frame_end   = 1'b1;
                        result.empty_frame = 1'b1;
                        phase_next         = PH_FIRST;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                key_next     = {key_reg[23:0], rx_byte};
                key_idx_next = key_idx_reg + 2'd1;
                if (key_idx_reg == 2'd3) begin
                    if (remaining_reg == 64'd0) begin
                        result.valid       = 1'b1;
                        result.frame_end   = 1'b1;
                        result.empty_frame = 1'b1;
                        phase_next         = PH_FIRST;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                key_idx_next        = key_idx_reg + 2'd1;
                remaining_next      = remaining_reg - 64'd1;
                result.valid        = 1'b1;
                result.payload_byte = rx_byte ^ (masked_reg ? key_byte : 8'd0);
                result.frame_end    = (remaining_reg == 64'd1);
                if (remaining_reg == 64'd1) begin
                    phase_next = PH_FIRST;
                end
            end
            default: begin
                kind_next  = rx_byte[6:0];
                phase_next = PH_SECOND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            kind_reg      <= '0;
            masked_reg    <= 1'b0;
            ext_cnt_reg   <= '0;
            remaining_reg <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            masked_reg    <= masked_next;
            ext_cnt_reg   <= ext_cnt_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer: one received byte in per transaction, unmasked
// payload bytes out. A result is registered and presented in the cycle after its byte.
// Throughput: 1 byte per cycle while m_axis_tready is high, set by the single parser
// state register stage; the output register drains while the next byte is taken.
// Reset: synchronous aresetn low returns to the first-header-byte phase and
// drops any pending result. Depends on wsd_pkg, wsd_parser, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module websocket_frame_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic            m_axis_tlast,   // frame_end
    output logic [7:0]      m_axis_tuser    // [6:0] frame_kind, [7] empty_frame
);
    import wsd_pkg::*;

    logic        accept;
    wsd_result_t result;

    logic        valid_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [7:0]  user_reg;

    // Take a byte whenever the output slot is free or being emptied
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .rx_byte (s_axis_tdata),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= result.valid;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload side holds while stalled, so no reset needed
    always_ff @(posedge aclk) begin
        if (accept && result.valid) begin
            data_reg <= result.payload_byte;
            last_reg <= result.frame_end;
            user_reg <= {result.empty_frame, result.frame_kind};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

    `WSD_ASSERT(a_empty_is_end, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser[7] |-> m_axis_tlast && m_axis_tdata == 8'd0,
        "empty frame marker without end mark or with data")
    `WSD_NEVER(a_no_take_when_full, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready && s_axis_tready,
        "input taken while a stalled result holds the output")
    `WSD_ASSERT(a_held_result_stays, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser),
        "stalled result changed")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of websocket_frame_deframer: framed byte streams in,
// unmasked payload bytes checked against a cycle-free predictor of the parser.
// Depends on wsd_pkg for the length codes; needs nothing beyond the RTL.

module tb_top;
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PS_FIRST,
        PS_SECOND,
        PS_EXTLEN,
        PS_KEY,
        PS_PAYLOAD
    } parse_state_t;

    typedef enum int {
        ENC_SHORT,
        ENC_EXT16,
        ENC_EXT64
    } len_enc_t;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] kind;
        logic       last;
        logic       empty;
    } deframed_t;

    localparam int RANDOM_BYTES = 1850;
    localparam int MAX_REPORTS  = 10;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [7:0] m_axis_tuser;

    logic [7:0] rx_stream[$];
    deframed_t  frames_expected[$];

    int  bytes_sent = 0;
    int  total_bytes = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  failures = 0;

    // Predictor state
    parse_state_t hdr_state = PS_FIRST;
    logic [6:0]   cur_kind = '0;
    logic         cur_masked = 1'b0;
    logic [3:0]   ext_left = '0;
    logic [63:0]  bytes_left = '0;
    logic [31:0]  cur_key = '0;
    logic [1:0]   key_idx = '0;

    websocket_frame_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] payload_byte
        .m_axis_tlast  (m_axis_tlast),   // frame_end
        .m_axis_tuser  (m_axis_tuser)    // [6:0] frame_kind, [7] empty_frame
    );

    initial forever #5 aclk = ~aclk;

    // Append one byte to the tail of the stream
    task automatic put_byte(input logic [7:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endtask

    // Append one expected result to the tail of the scoreboard
    task automatic expect_result(input deframed_t r);
        frames_expected.insert(frames_expected.size(), r);
    endtask

    task automatic finish_header();
        key_idx = 2'd0;
        if (bytes_left == 64'd0) begin
            expect_result('{data: 8'h00, kind: cur_kind, last: 1'b1, empty: 1'b1});
            hdr_state = PS_FIRST;
        end else begin
            hdr_state = PS_PAYLOAD;
        end
    endtask

    task automatic finish_length();
        if (cur_masked) begin
            key_idx = 2'd0;
            cur_key = '0;
            hdr_state = PS_KEY;
        end else begin
            finish_header();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        case (hdr_state)
            PS_SECOND: begin
                cur_masked = b[7];
                bytes_left = '0;
                if (b[6:0] == LEN_EXT16) begin
                    ext_left = EXT16_BYTES;
                    hdr_state = PS_EXTLEN;
                end else if (b[6:0] == LEN_EXT64) begin
                    ext_left = EXT64_BYTES;
                    hdr_state = PS_EXTLEN;
                end else begin
                    bytes_left = {57'd0, b[6:0]};
                    finish_length();
                end
            end
            PS_EXTLEN: begin
                bytes_left = {bytes_left[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0) finish_length();
            end
            PS_KEY: begin
                cur_key = {cur_key[23:0], b};
                key_idx = key_idx + 2'd1;
                if (key_idx == 2'd0) finish_header();
            end
            PS_PAYLOAD: begin
                v = b;
                // key byte 0 sits in the top byte of the key word
                if (cur_masked) v = b ^ 8'(cur_key >> (8 * (3 - key_idx)));
                key_idx = key_idx + 2'd1;
                bytes_left = bytes_left - 64'd1;
                expect_result('{data: v, kind: cur_kind,
                                last: (bytes_left == 64'd0), empty: 1'b0});
                if (bytes_left == 64'd0) hdr_state = PS_FIRST;
            end
            default: begin
                cur_kind = b[6:0];
                hdr_state = PS_SECOND;
            end
        endcase
    endtask

    // Append one frame; body is the number of payload bytes actually queued,
    // fill below zero asks for random payload.
    task automatic add_frame(input logic [7:0] first, input logic masked, input len_enc_t enc,
                             input logic [63:0] len, input int body, input int fill);
        logic [31:0] mask_word;
        int i;
        mask_word = $urandom;
        put_byte(first);
        case (enc)
            ENC_SHORT: put_byte({masked, len[6:0]});
            ENC_EXT16: begin
                put_byte({masked, LEN_EXT16});
                put_byte(len[15:8]);
                put_byte(len[7:0]);
            end
            default: begin
                put_byte({masked, LEN_EXT64});
                for (i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
            end
        endcase
        if (masked) begin
            for (i = 3; i >= 0; i--) put_byte(mask_word[8*i +: 8]);
        end
        for (i = 0; i < body; i++) begin
            put_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        end
    endtask

    task automatic report_result(input string what, input deframed_t want, input deframed_t got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%0t %s: want data %02h kind %02h last %b empty %b,",
                     $realtime, what, want.data, want.kind, want.last, want.empty,
                     " got data %02h kind %02h last %b empty %b",
                     got.data, got.kind, got.last, got.empty);
        end
    endtask

    // Driver: predict on each accepted transaction, then refill the slot
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= rx_stream.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_monitor
        deframed_t got;
        deframed_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{data: m_axis_tdata, kind: m_axis_tuser[6:0],
                        last: m_axis_tlast, empty: m_axis_tuser[7]};
                if (frames_expected.size() == 0) begin
                    report_result("unexpected result", 'x, got);
                end else begin
                    want = frames_expected.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.last !== want.last || got.empty !== want.empty) begin
                        report_result("mismatch", want, got);
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (aresetn);
        while (bytes_sent < 40) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_seq
        int idle_tab[4];
        int stall_tab[4];
        int ph;
        int pick;
        logic masked;
        logic [63:0] len;
        int base;
        idle_tab = '{0, 47, 0, 18};
        stall_tab = '{0, 0, 47, 18};

        // Directed frames: empty frames, extremes, extended lengths
        add_frame(8'h81, 1'b0, ENC_SHORT, 64'd0, 0, -1);
        add_frame(8'hFF, 1'b1, ENC_SHORT, 64'd0, 0, -1);
        add_frame(8'h00, 1'b1, ENC_SHORT, 64'd2, 2, 255);
        add_frame(8'h88, 1'b0, ENC_EXT16, 64'd0, 0, -1);
        add_frame(8'h09, 1'b0, ENC_EXT64, 64'd1, 1, 0);
        add_frame(8'h7F, 1'b1, ENC_EXT16, 64'd3, 3, -1);
        base = rx_stream.size();

        // Random frames, mostly short ones
        while (rx_stream.size() < base + RANDOM_BYTES) begin
            pick = $urandom_range(99);
            masked = 1'($urandom_range(1));
            if (pick < 70) begin
                len = 64'($urandom_range(20));
                add_frame(8'($urandom_range(255)), masked, ENC_SHORT, len, int'(len), -1);
            end else if (pick < 72) begin
                add_frame(8'($urandom_range(255)), masked, ENC_SHORT, 64'd125, 125, -1);
            end else if (pick < 78) begin
                len = 64'($urandom_range(125));
                add_frame(8'($urandom_range(255)), masked, ENC_SHORT, len, int'(len), -1);
            end else if (pick < 90) begin
                len = ($urandom_range(9) == 0) ? 64'($urandom_range(300))
                                               : 64'($urandom_range(24));
                add_frame(8'($urandom_range(255)), masked, ENC_EXT16, len, int'(len), -1);
            end else begin
                len = 64'($urandom_range(24));
                add_frame(8'($urandom_range(255)), masked, ENC_EXT64, len, int'(len), -1);
            end
        end
        // 64-bit length with its top bit set: taken as is, never completes
        add_frame(8'h8A, 1'b0, ENC_EXT64, 64'h8000_0000_0000_0000, 5, -1);
        total_bytes = rx_stream.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < 4; ph++) begin
            sender_idle_pct <= idle_tab[ph];
            recv_stall_pct <= stall_tab[ph];
            while (bytes_sent < ((ph + 1) * total_bytes) / 4) @(posedge aclk);
        end
        while (rx_stream.size() != 0 || s_axis_tvalid || frames_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (failures == 0 && frames_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== websocket_frame_deframer.f =====
+incdir+hdl
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/websocket_frame_deframer.sv
verif/tb_top.sv
